### hdl/gbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbp_pkg
// Shared types and constants for the gshare branch predictor.
// ----------------------------------------------------------------------------
package gbp_pkg;

	localparam int CFG_W   = 4;
	localparam int APB_DW  = 32;
	localparam int APB_AW  = 3;

	// register indexes (word address, paddr[2])
	localparam logic REG_INDEX_BITS   = 1'b0;
	localparam logic REG_COUNTER_BITS = 1'b1;

	localparam logic [CFG_W-1:0] RST_INDEX_BITS   = 4'd12;
	localparam logic [CFG_W-1:0] RST_COUNTER_BITS = 4'd2;

	typedef struct packed {
		logic [CFG_W-1:0] index_bits;
		logic [CFG_W-1:0] counter_bits;
	} cfg_t;

endpackage

### hdl/gbp_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbp_regs
// APB register file holding the index and counter widths.
// ----------------------------------------------------------------------------
module gbp_regs
	import gbp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.index_bits   <= RST_INDEX_BITS;
			cfg_q.counter_bits <= RST_COUNTER_BITS;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_INDEX_BITS:   cfg_q.index_bits   <= pwdata[CFG_W-1:0];
				REG_COUNTER_BITS: cfg_q.counter_bits <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_INDEX_BITS:   prdata = {{(APB_DW-CFG_W){1'b0}}, cfg_q.index_bits};
			REG_COUNTER_BITS: prdata = {{(APB_DW-CFG_W){1'b0}}, cfg_q.counter_bits};
			default:          prdata = '0;
		endcase
	end

endmodule

### hdl/gbp_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbp_table
// Counter table: synchronous RAM with read-modify-write, forwarding and a
// clearing sweep after reset.
// ----------------------------------------------------------------------------
module gbp_table
	import gbp_pkg::*;
#(
	parameter int IDXW = 12,
	parameter int CW   = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  cfg_t            cfg,
	input  logic            acc,
	input  logic [IDXW-1:0] idx,
	input  logic            taken,
	output logic            busy,
	output logic            pred_valid,
	output logic            pred
);

	localparam int DEPTH = 2 ** IDXW;
	localparam int ECB_W = $clog2(CW + 1);

	logic [CW-1:0] mem [DEPTH];

	logic            clearing_q;
	logic [IDXW-1:0] clr_addr_q;

	logic            v_s1;
	logic [IDXW-1:0] idx_s1;
	logic            taken_s1;
	logic [CW-1:0]   rd_s1;
	logic            fwd_s1;
	logic [CW-1:0]   fwd_data_s1;

	logic            res_v_q;
	logic            pred_q;

	logic [ECB_W-1:0] ecb;
	logic [CW-1:0]    cmax;
	logic [CW-1:0]    low_mask;
	logic [CW-1:0]    cur;
	logic [CW-1:0]    nxt;
	logic             pred_c;

	logic            we;
	logic [IDXW-1:0] wa;
	logic [CW-1:0]   wd;

	assign busy       = clearing_q;
	assign pred_valid = res_v_q;
	assign pred       = pred_q;

	// clamp counter width to 1..CW
	always_comb begin
		if (cfg.counter_bits == '0)
			ecb = ECB_W'(1);
		else if (int'(cfg.counter_bits) > CW)
			ecb = ECB_W'(CW);
		else
			ecb = ECB_W'(cfg.counter_bits);
	end

	always_comb begin
		for (int i = 0; i < CW; i++) begin
			cmax[i]     = (i < int'(ecb));
			low_mask[i] = ((i + 1) < int'(ecb));
		end
	end

	assign cur    = fwd_s1 ? fwd_data_s1 : rd_s1;
	// taken once any bit at or above the threshold bit is set
	assign pred_c = |(cur & ~low_mask);

	always_comb begin
		if (taken_s1)
			nxt = (cur >= cmax) ? cmax : cur + CW'(1);
		else
			nxt = (cur != '0) ? cur - CW'(1) : cur;
	end

	assign we = clearing_q || v_s1;
	assign wa = clearing_q ? clr_addr_q : idx_s1;
	assign wd = clearing_q ? '0 : nxt;

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		if (acc)
			rd_s1 <= mem[idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
			v_s1       <= 1'b0;
			fwd_s1     <= 1'b0;
			res_v_q    <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + IDXW'(1);
				if (clr_addr_q == {IDXW{1'b1}})
					clearing_q <= 1'b0;
			end
			v_s1    <= acc;
			// RAM read misses the write landing on the same edge
			fwd_s1  <= acc && v_s1 && (idx == idx_s1);
			res_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			idx_s1   <= idx;
			taken_s1 <= taken;
		end
		fwd_data_s1 <= nxt;
		pred_q      <= pred_c;
	end

endmodule

### hdl/gshare_branch_predictor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gshare_branch_predictor
// Gshare predictor: history-hashed index into a table of saturating counters.
// ----------------------------------------------------------------------------
// Timing: each accepted item passes through the table's v_s1 and res_v_q registers
// before result_valid pulses. Throughput: one item per cycle while busy is low; the RAM read-modify-write is forwarded.
// Reset: after arst_n the table is cleared one entry a cycle, all 2**MAX_INDEX_BITS
// entries (4096 by default), with busy high; registers are writable meanwhile.
// The receiver cannot stall: each result is shown for exactly one cycle.
module gshare_branch_predictor
	import gbp_pkg::*;
#(
	parameter int MAX_INDEX_BITS = 12,
	parameter int COUNTER_WIDTH  = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [31:0]       branch_address,
	input  logic              actual_taken,
	output logic              result_valid,
	output logic              predict_taken,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int IDXW  = MAX_INDEX_BITS;
	localparam int EIB_W = $clog2(IDXW + 1);

	cfg_t            cfg;
	logic            acc;
	logic [IDXW-1:0] hist_q;
	logic [EIB_W-1:0] eib;
	logic [IDXW-1:0] imask;
	logic [IDXW-1:0] idx;

	gbp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign acc = start && !busy;

	always_comb begin
		if (cfg.index_bits == '0)
			eib = EIB_W'(1);
		else if (int'(cfg.index_bits) > IDXW)
			eib = EIB_W'(IDXW);
		else
			eib = EIB_W'(cfg.index_bits);
	end

	always_comb begin
		for (int i = 0; i < IDXW; i++)
			imask[i] = (i < int'(eib));
	end

	assign idx = (branch_address[IDXW-1:0] ^ hist_q) & imask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hist_q <= '0;
		else if (acc)
			hist_q <= (hist_q << 1) | IDXW'(actual_taken);
	end

	gbp_table #(
		.IDXW (IDXW),
		.CW   (COUNTER_WIDTH)
	) u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.acc        (acc),
		.idx        (idx),
		.taken      (actual_taken),
		.busy       (busy),
		.pred_valid (result_valid),
		.pred       (predict_taken)
	);

	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> ##2 result_valid)
		else $error("result missing two cycles after accept");

	a_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(acc, 2))
		else $error("result without an accepted item");

	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !busy)
		else $error("busy rose after the clearing sweep");

endmodule

### dv/gshare_branch_predictor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gshare_branch_predictor_tb
// Drives resolved branches into the gshare predictor. A scoreboard keeps its
// own copy of the history, the counter table and both registers, and checks
// each prediction against it. The run covers several register settings,
// out-of-range widths among them, with random gaps on the input side.
// ----------------------------------------------------------------------------
module gshare_branch_predictor_tb;
	import gbp_pkg::*;

	localparam int MAX_IDX    = 12;
	localparam int CTR_W      = 8;
	localparam int PHASE_LEN  = 85;
	localparam int POOL_SIZE  = 8;
	localparam int SETTLE     = 6;
	localparam int STALL_MAX  = 12000;  // covers the table clear after reset

	class gshare_scoreboard;
		bit [CFG_W-1:0]   index_bits   = RST_INDEX_BITS;
		bit [CFG_W-1:0]   counter_bits = RST_COUNTER_BITS;
		bit [MAX_IDX-1:0] history;
		bit [CTR_W-1:0]   counters [2**MAX_IDX];
		bit               predictions [$];
		int               errors;

		function void set_reg(logic idx, bit [CFG_W-1:0] val);
			if (idx == REG_INDEX_BITS)
				index_bits = val;
			else
				counter_bits = val;
		endfunction

		function void note_branch(bit [31:0] addr, bit taken);
			int unsigned ib, cb, imask, cmax, thresh, idx, c;
			ib = index_bits;
			if (ib < 1) ib = 1;
			if (ib > MAX_IDX) ib = MAX_IDX;
			cb = counter_bits;
			if (cb < 1) cb = 1;
			if (cb > CTR_W) cb = CTR_W;
			imask  = (1 << ib) - 1;
			cmax   = (1 << cb) - 1;
			thresh = 1 << (cb - 1);
			idx = (addr ^ history) & imask;
			c = counters[idx];
			predictions.push_back(c >= thresh);
			// on a taken branch a counter left above the maximum by a narrower width saturates down to it
			if (taken) begin
				c = c + 1;
				if (c > cmax) c = cmax;
			end else if (c > 0) begin
				c = c - 1;
			end
			counters[idx] = CTR_W'(c);
			history = {history[MAX_IDX-2:0], taken};
		endfunction

		function void check_result(bit got);
			bit want;
			if (predictions.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: prediction %0b with no item outstanding", $realtime, got);
			end else begin
				want = predictions.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display("%0t: predict_taken expected %0b got %0b",
							$realtime, want, got);
				end
			end
		endfunction

		function int pending();
			return predictions.size();
		endfunction
	endclass

	typedef struct {
		bit [CFG_W-1:0] ib;
		bit [CFG_W-1:0] cb;
		int             lean;
	} phase_t;

	logic              clk            = 1'b0;
	logic              arst_n         = 1'b0;
	logic              start          = 1'b0;
	logic              busy;
	logic [31:0]       branch_address = '0;
	logic              actual_taken   = 1'b0;
	logic              result_valid;
	logic              predict_taken;
	logic              psel           = 1'b0;
	logic              penable        = 1'b0;
	logic              pwrite         = 1'b0;
	logic [APB_AW-1:0] paddr          = '0;
	logic [APB_DW-1:0] pwdata         = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	gshare_scoreboard sb = new();
	int               stall_cycles;
	int               quiet;

	gshare_branch_predictor #(
		.MAX_INDEX_BITS(MAX_IDX),
		.COUNTER_WIDTH (CTR_W)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.branch_address(branch_address),
		.actual_taken  (actual_taken),
		.result_valid  (result_valid),
		.predict_taken (predict_taken),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid)
			sb.check_result(predict_taken);
	end

	// no item in and no result out for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_MAX) begin
			$display("status: fail");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// called at a rising edge; returns at the edge after the access phase
	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
		logic [APB_DW-1:0] word;
		word = ($urandom() & ~32'hF) | val;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, val);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// called at a rising edge; returns at the edge that accepts the item
	task automatic send_branch(input logic [31:0] addr, input logic taken, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start          <= 1'b1;
		branch_address <= addr;
		actual_taken   <= taken;
		do @(posedge clk); while (busy);
		sb.note_branch(addr, taken);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic int draw_gap();
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		if ($urandom_range(0, 9) == 0)
			quiet = $urandom_range(10, 40);
		return $urandom_range(0, 12);
	endfunction

	phase_t phases [10] = '{
		'{4'd12, 4'd2,  80}, '{4'd1,  4'd1,  70}, '{4'd0,  4'd0,  60},
		'{4'd15, 4'd15, 90}, '{4'd3,  4'd8,  95}, '{4'd3,  4'd2,  50},
		'{4'd5,  4'd9,  95}, '{4'd5,  4'd1,  30}, '{4'd13, 4'd4,  85},
		'{4'd2,  4'd7,  70}
	};

	logic [31:0] directed_addr [10] = '{
		32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h5555_5555,
		32'hAAAA_AAAA, 32'h0000_0FFF, 32'hFFFF_F000, 32'h0000_0800, 32'h0000_0000
	};

	initial begin
		logic [31:0] pool     [POOL_SIZE];
		int          pool_pct [POOL_SIZE];
		int          k;
		logic [31:0] addr;
		logic        taken;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: address extremes, then one branch trained up and back down
		for (int i = 0; i < 10; i++)
			send_branch(directed_addr[i], i[0], (i == 4) ? 3 : 0);
		for (int i = 0; i < 12; i++)
			send_branch(32'h0000_0000, i < 7, 0);

		foreach (phases[p]) begin
			drain();
			write_reg(REG_INDEX_BITS, phases[p].ib);
			write_reg(REG_COUNTER_BITS, phases[p].cb);
			for (int i = 0; i < POOL_SIZE; i++) begin
				pool[i]     = $urandom();
				pool_pct[i] = (i < 6) ? phases[p].lean : 100 - phases[p].lean;
			end
			for (int n = 0; n < PHASE_LEN; n++) begin
				if ($urandom_range(0, 99) < 70) begin
					k     = $urandom_range(0, POOL_SIZE - 1);
					addr  = pool[k];
					taken = $urandom_range(0, 99) < pool_pct[k];
				end else begin
					addr  = $urandom();
					taken = 1'($urandom_range(0, 1));
				end
				send_branch(addr, taken, draw_gap());
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

### files.f
hdl/gbp_pkg.sv
hdl/gbp_regs.sv
hdl/gbp_table.sv
hdl/gshare_branch_predictor.sv
dv/gshare_branch_predictor_tb.sv
